### src/mlcm_pkg.sv
`default_nettype none

package mlcm_pkg;

    // default sizes
    localparam int DEF_NUM_LISTS  = 16;
    localparam int DEF_NUM_NODES  = 128;
    localparam int DEF_ITEM_WIDTH = 32;

    // stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // command codes
    localparam logic [3:0] OP_CREATE     = 4'd0;
    localparam logic [3:0] OP_FREE       = 4'd1;
    localparam logic [3:0] OP_COUNT      = 4'd2;
    localparam logic [3:0] OP_FIRST      = 4'd3;
    localparam logic [3:0] OP_LAST       = 4'd4;
    localparam logic [3:0] OP_NEXT       = 4'd5;
    localparam logic [3:0] OP_PREV       = 4'd6;
    localparam logic [3:0] OP_CURR       = 4'd7;
    localparam logic [3:0] OP_INS_AFTER  = 4'd8;
    localparam logic [3:0] OP_INS_BEFORE = 4'd9;
    localparam logic [3:0] OP_APPEND     = 4'd10;
    localparam logic [3:0] OP_PREPEND    = 4'd11;
    localparam logic [3:0] OP_REMOVE     = 4'd12;
    localparam logic [3:0] OP_TRIM       = 4'd13;
    localparam logic [3:0] OP_CONCAT     = 4'd14;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

endpackage

`default_nettype wire

### src/mlcm_node_mem.sv
`default_nettype none

module mlcm_node_mem #(
    parameter int NUM_NODES  = mlcm_pkg::DEF_NUM_NODES,
    parameter int ITEM_WIDTH = mlcm_pkg::DEF_ITEM_WIDTH
) (
    input  wire logic                           i_clk,
    // successor links
    input  wire logic [$clog2(NUM_NODES)-1:0]   i_nx_raddr,
    output logic      [$clog2(NUM_NODES):0]     o_nx_rdata,
    input  wire logic                           i_nx_we,
    input  wire logic [$clog2(NUM_NODES)-1:0]   i_nx_waddr,
    input  wire logic [$clog2(NUM_NODES):0]     i_nx_wdata,
    // predecessor links
    input  wire logic [$clog2(NUM_NODES)-1:0]   i_pv_raddr,
    output logic      [$clog2(NUM_NODES):0]     o_pv_rdata,
    input  wire logic                           i_pv_we,
    input  wire logic [$clog2(NUM_NODES)-1:0]   i_pv_waddr,
    input  wire logic [$clog2(NUM_NODES):0]     i_pv_wdata,
    // item words, read at the successor address
    input  wire logic                           i_it_we,
    input  wire logic [$clog2(NUM_NODES)-1:0]   i_it_waddr,
    input  wire logic [ITEM_WIDTH-1:0]          i_it_wdata,
    output logic      [ITEM_WIDTH-1:0]          o_it_rdata
);
    localparam int NIW = $clog2(NUM_NODES);

    logic [NIW:0]            r_next_mem [NUM_NODES];
    logic [NIW:0]            r_prev_mem [NUM_NODES];
    logic [ITEM_WIDTH-1:0]   r_item_mem [NUM_NODES];

    // one write and one registered read per array
    always_ff @(posedge i_clk) begin
        if (i_nx_we) begin
            r_next_mem[i_nx_waddr] <= i_nx_wdata;
        end
        if (i_pv_we) begin
            r_prev_mem[i_pv_waddr] <= i_pv_wdata;
        end
        if (i_it_we) begin
            r_item_mem[i_it_waddr] <= i_it_wdata;
        end
        o_nx_rdata <= r_next_mem[i_nx_raddr];
        o_pv_rdata <= r_prev_mem[i_pv_raddr];
        o_it_rdata <= r_item_mem[i_nx_raddr];
    end

endmodule

`default_nettype wire

### src/multi_list_cursor_manager.sv
`default_nettype none

// channel   direction  ports                          tdata fields (lsb first)
// command   in         i_s_tvalid/o_s_tready/i_s_tdata operation, list_handle,
//                                                      second_handle, item_value
// response  out        o_m_tvalid/i_m_tready/o_m_tdata status, item_out,
//                                                      node_count, new_handle
//
// one command at a time; count, create and bad handles go straight from decode to the
// output step, while cursor reads, inserts, remove, trim, concat and free pass through
// more states (free once per node freed); the cost is set by the registered read of the node link memories
// reset is synchronous; the node pool needs no clearing pass (unused nodes come
// from a fill counter), the head table is cleared at once
// a stalled response holds the block in its output step; a new command is taken
// as soon as the previous result sits in the output register

module multi_list_cursor_manager #(
    parameter int NUM_LISTS  = mlcm_pkg::DEF_NUM_LISTS,
    parameter int NUM_NODES  = mlcm_pkg::DEF_NUM_NODES,
    parameter int ITEM_WIDTH = mlcm_pkg::DEF_ITEM_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // operation[3:0], list_handle[7:4], second_handle[11:8], item_value[43:12]
    input  wire logic [mlcm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // status[1:0], item_out[33:2], node_count[41:34], new_handle[45:42]
    output logic      [mlcm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import mlcm_pkg::*;

    localparam int NIW = $clog2(NUM_NODES);
    localparam int NW  = NIW + 1;
    localparam int HIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int HW  = HIW + 1;
    localparam int RHW = (HIW > 4) ? HIW : 4;
    localparam int SW  = $clog2(NUM_NODES + 1);
    localparam logic [NW-1:0]  NODE_NIL = NW'(NUM_NODES);
    localparam logic [HW-1:0]  HEAD_NIL = HW'(NUM_LISTS);
    localparam logic [RHW:0]   NUM_H    = NUM_LISTS[RHW:0];
    localparam logic [SW-1:0]  NUM_N    = SW'(NUM_NODES);

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_RD, S_SHOW, S_RDN, S_NAV, S_INS_W, S_INS_A,
        S_INS_W2, S_INS_B, S_INS_C, S_UNW, S_UN1, S_UN2, S_CAT1, S_CAT2, S_OUT
    } t_state;

    t_state r_state;

    // head table
    logic [NW-1:0] r_first [NUM_LISTS];
    logic [NW-1:0] r_last  [NUM_LISTS];
    logic [NW-1:0] r_cur   [NUM_LISTS];
    logic [SW-1:0] r_size  [NUM_LISTS];
    logic          r_pe    [NUM_LISTS];
    logic          r_inuse [NUM_LISTS];
    logic [HW-1:0] r_nfree [NUM_LISTS];
    logic [HW-1:0] r_fhi;

    // node pool
    logic [NW-1:0] r_fhead;
    logic [SW-1:0] r_fill;

    // command and work registers
    logic [3:0]            r_op;
    logic [RHW-1:0]        r_h;
    logic [RHW-1:0]        r_h2;
    logic [ITEM_WIDTH-1:0] r_val;
    logic [NW-1:0]         r_n;
    logic [NW-1:0]         r_m;
    logic [NW-1:0]         r_new;
    logic [NW-1:0]         r_at;
    logic [NW-1:0]         r_nx;
    logic [NW-1:0]         r_l1;
    logic [SW-1:0]         r_size1;
    logic                  r_from;
    logic                  r_atprev;
    logic                  r_cnt_ok;
    logic [1:0]            r_res_status;
    logic [ITEM_WIDTH-1:0] r_res_item;
    logic [3:0]            r_res_newh;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // memory signals
    logic [NW-1:0]         nx_rd;
    logic [NW-1:0]         pv_rd;
    logic [ITEM_WIDTH-1:0] it_rd;
    logic                  nx_we;
    logic [NW-1:0]         nx_waddr;
    logic [NW-1:0]         nx_wdata;
    logic                  pv_we;
    logic [NW-1:0]         pv_waddr;
    logic [NW-1:0]         pv_wdata;

    // head table read port
    logic [HIW-1:0] hsel;
    logic [HIW-1:0] hidx;
    logic [HIW-1:0] hidx2;
    logic [NW-1:0]  hf;
    logic [NW-1:0]  hl;
    logic [NW-1:0]  hc;
    logic [SW-1:0]  hs;
    logic           hp;
    logic           h_ok;
    logic           live;
    logic           live2;
    logic           fwd;
    logic [7:0]     cnt;

    function automatic logic nd(input logic [NW-1:0] p);
        return p < NODE_NIL;
    endfunction

    assign hidx  = HIW'(r_h);
    assign hidx2 = HIW'(r_h2);
    assign hsel  = (r_state == S_CAT1) ? hidx2 : hidx;
    assign hf    = r_first[hsel];
    assign hl    = r_last[hsel];
    assign hc    = r_cur[hsel];
    assign hs    = r_size[hsel];
    assign hp    = r_pe[hsel];
    assign h_ok  = {1'b0, r_h} < NUM_H;
    assign live  = h_ok && r_inuse[hsel];
    assign live2 = ({1'b0, r_h2} < NUM_H) && r_inuse[hsel] && (r_h2 != r_h);
    assign fwd   = (r_op == OP_NEXT);
    assign cnt   = (r_cnt_ok && live) ? 8'(hs) : 8'd0;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // node link writes
    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = r_new;
        nx_wdata = r_at;
        pv_we    = 1'b0;
        pv_waddr = r_new;
        pv_wdata = r_at;
        case (r_state)
            S_INS_B: begin
                nx_we    = 1'b1;
                nx_wdata = nd(r_at) ? nx_rd : hf;
                pv_we    = 1'b1;
            end
            S_INS_C: begin
                nx_we    = nd(r_at);
                nx_waddr = r_at;
                nx_wdata = r_new;
                pv_we    = nd(r_nx);
                pv_waddr = r_nx;
                pv_wdata = r_new;
            end
            S_UN1: begin
                nx_we    = nd(pv_rd);
                nx_waddr = pv_rd;
                nx_wdata = nx_rd;
                pv_we    = nd(nx_rd);
                pv_waddr = nx_rd;
                pv_wdata = pv_rd;
            end
            S_UN2: begin
                nx_we    = 1'b1;
                nx_waddr = r_n;
                nx_wdata = r_fhead;
            end
            S_CAT1: begin
                nx_we    = live2 && nd(hf) && nd(r_l1);
                nx_waddr = r_l1;
                nx_wdata = hf;
                pv_we    = live2 && nd(hf) && nd(r_l1);
                pv_waddr = hf;
                pv_wdata = r_l1;
            end
            default: begin
            end
        endcase
    end

    mlcm_node_mem #(
        .NUM_NODES  (NUM_NODES),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_node_mem (
        .i_clk      (i_clk),
        .i_nx_raddr (r_n[NIW-1:0]),
        .o_nx_rdata (nx_rd),
        .i_nx_we    (nx_we),
        .i_nx_waddr (nx_waddr[NIW-1:0]),
        .i_nx_wdata (nx_wdata),
        .i_pv_raddr (r_m[NIW-1:0]),
        .o_pv_rdata (pv_rd),
        .i_pv_we    (pv_we),
        .i_pv_waddr (pv_waddr[NIW-1:0]),
        .i_pv_wdata (pv_wdata),
        .i_it_we    (r_state == S_INS_A),
        .i_it_waddr (r_new[NIW-1:0]),
        .i_it_wdata (r_val),
        .o_it_rdata (it_rd)
    );

    // command sequencer, head table and output register
    always_ff @(posedge i_clk) begin
        logic [NW-1:0]  v_c;
        logic [HIW-1:0] v_nh;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fhead     <= NODE_NIL;
            r_fill      <= '0;
            r_fhi       <= '0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_first[i] <= NODE_NIL;
                r_last[i]  <= NODE_NIL;
                r_cur[i]   <= NODE_NIL;
                r_size[i]  <= '0;
                r_pe[i]    <= 1'b0;
                r_inuse[i] <= 1'b0;
                r_nfree[i] <= HW'(i + 1);
            end
        end else begin
            v_c  = NODE_NIL;
            v_nh = r_fhi[HIW-1:0];
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tdata[3:0];
                        r_h     <= RHW'(i_s_tdata[7:4]);
                        r_h2    <= RHW'(i_s_tdata[11:8]);
                        r_val   <= ITEM_WIDTH'(i_s_tdata[43:12]);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_status <= ST_NONE;
                    r_res_item   <= '0;
                    r_res_newh   <= '0;
                    r_cnt_ok     <= 1'b1;
                    r_state      <= S_OUT;
                    if (r_op == OP_CREATE) begin
                        if (r_fhi < HEAD_NIL) begin
                            r_fhi         <= r_nfree[v_nh];
                            r_nfree[v_nh] <= HEAD_NIL;
                            r_inuse[v_nh] <= 1'b1;
                            r_first[v_nh] <= NODE_NIL;
                            r_last[v_nh]  <= NODE_NIL;
                            r_cur[v_nh]   <= NODE_NIL;
                            r_size[v_nh]  <= '0;
                            r_pe[v_nh]    <= 1'b0;
                            r_h           <= RHW'(r_fhi);
                            r_res_newh    <= 4'(r_fhi);
                            r_res_status  <= ST_OK;
                        end else begin
                            r_res_status <= ST_NOFREE;
                            r_cnt_ok     <= 1'b0;
                        end
                    end else if (live) begin
                        case (r_op) inside
                            OP_FREE, OP_TRIM: begin
                                if (nd(hl)) begin
                                    r_n     <= hl;
                                    r_m     <= hl;
                                    r_state <= S_UNW;
                                end else if (r_op == OP_FREE) begin
                                    // empty list: release the head now
                                    r_inuse[hidx] <= 1'b0;
                                    r_nfree[hidx] <= r_fhi;
                                    r_fhi         <= HW'(hidx);
                                    r_first[hidx] <= NODE_NIL;
                                    r_last[hidx]  <= NODE_NIL;
                                    r_cur[hidx]   <= NODE_NIL;
                                    r_size[hidx]  <= '0;
                                    r_pe[hidx]    <= 1'b0;
                                    r_res_status  <= ST_OK;
                                end
                            end
                            OP_COUNT: begin
                                r_res_status <= ST_OK;
                            end
                            OP_FIRST, OP_LAST: begin
                                v_c = (r_op == OP_FIRST) ? hf : hl;
                                r_cur[hidx] <= v_c;
                                r_pe[hidx]  <= 1'b0;
                                if (nd(v_c)) begin
                                    r_n     <= v_c;
                                    r_state <= S_RD;
                                end
                            end
                            OP_NEXT, OP_PREV: begin
                                if (nd(hc)) begin
                                    r_n     <= hc;
                                    r_m     <= hc;
                                    r_state <= S_RDN;
                                end else begin
                                    // parked cursor re-enters from the matching end
                                    if (hp != fwd) begin
                                        v_c = fwd ? hf : hl;
                                    end
                                    r_cur[hidx] <= v_c;
                                    r_pe[hidx]  <= nd(v_c) ? 1'b0 : fwd;
                                    if (nd(v_c)) begin
                                        r_n     <= v_c;
                                        r_state <= S_RD;
                                    end
                                end
                            end
                            OP_CURR: begin
                                if (nd(hc)) begin
                                    r_n     <= hc;
                                    r_state <= S_RD;
                                end
                            end
                            OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
                                if (nd(r_fhead) || (r_fill < NUM_N)) begin
                                    r_from   <= nd(r_fhead);
                                    r_new    <= nd(r_fhead) ? r_fhead : NW'(r_fill);
                                    if (!nd(r_fhead)) begin
                                        r_fill <= r_fill + 1'b1;
                                    end
                                    r_n      <= r_fhead;
                                    r_m      <= hc;
                                    r_atprev <= 1'b0;
                                    if (r_op == OP_APPEND) begin
                                        r_at <= hl;
                                    end else if (r_op == OP_PREPEND) begin
                                        r_at <= NODE_NIL;
                                    end else if (!nd(hc)) begin
                                        r_at <= hp ? hl : NODE_NIL;
                                    end else if (r_op == OP_INS_AFTER) begin
                                        r_at <= hc;
                                    end else begin
                                        r_atprev <= 1'b1;
                                    end
                                    r_state <= S_INS_W;
                                end else begin
                                    r_res_status <= ST_NOFREE;
                                end
                            end
                            OP_REMOVE: begin
                                if (nd(hc)) begin
                                    r_n     <= hc;
                                    r_m     <= hc;
                                    r_state <= S_UNW;
                                end
                            end
                            OP_CONCAT: begin
                                r_l1    <= hl;
                                r_size1 <= hs;
                                r_state <= S_CAT1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_SHOW;
                end
                S_SHOW: begin
                    r_res_status <= ST_OK;
                    r_res_item   <= it_rd;
                    r_state      <= S_OUT;
                end
                S_RDN: begin
                    r_state <= S_NAV;
                end
                S_NAV: begin
                    v_c = fwd ? nx_rd : pv_rd;
                    r_cur[hidx] <= v_c;
                    r_pe[hidx]  <= nd(v_c) ? 1'b0 : fwd;
                    if (nd(v_c)) begin
                        r_n     <= v_c;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_INS_W: begin
                    r_state <= S_INS_A;
                end
                // pop free list, settle the link point
                S_INS_A: begin
                    if (r_from) begin
                        r_fhead <= nx_rd;
                    end
                    v_c = r_atprev ? pv_rd : r_at;
                    r_at    <= v_c;
                    r_n     <= v_c;
                    r_state <= S_INS_W2;
                end
                S_INS_W2: begin
                    r_state <= S_INS_B;
                end
                S_INS_B: begin
                    r_nx    <= nd(r_at) ? nx_rd : hf;
                    r_state <= S_INS_C;
                end
                S_INS_C: begin
                    if (!nd(r_at)) begin
                        r_first[hidx] <= r_new;
                    end
                    if (!nd(r_nx)) begin
                        r_last[hidx] <= r_new;
                    end
                    r_size[hidx] <= hs + 1'b1;
                    r_cur[hidx]  <= r_new;
                    r_pe[hidx]   <= 1'b0;
                    r_res_status <= ST_OK;
                    r_state      <= S_OUT;
                end
                S_UNW: begin
                    r_state <= S_UN1;
                end
                // unlink node r_n
                S_UN1: begin
                    if (!nd(pv_rd)) begin
                        r_first[hidx] <= nx_rd;
                    end
                    if (!nd(nx_rd)) begin
                        r_last[hidx] <= pv_rd;
                    end
                    if (hs != '0) begin
                        r_size[hidx] <= hs - 1'b1;
                    end
                    if (r_op == OP_TRIM) begin
                        r_cur[hidx] <= pv_rd;
                        r_pe[hidx]  <= 1'b0;
                    end else begin
                        r_cur[hidx] <= nx_rd;
                        r_pe[hidx]  <= !nd(nx_rd);
                    end
                    r_res_item <= it_rd;
                    r_state    <= S_UN2;
                end
                // return node to the pool, continue a free walk
                S_UN2: begin
                    r_fhead <= r_n;
                    if (r_op != OP_FREE) begin
                        r_res_status <= ST_OK;
                        r_state      <= S_OUT;
                    end else if (nd(hl)) begin
                        r_n     <= hl;
                        r_m     <= hl;
                        r_state <= S_UNW;
                    end else begin
                        r_inuse[hidx] <= 1'b0;
                        r_nfree[hidx] <= r_fhi;
                        r_fhi         <= HW'(hidx);
                        r_first[hidx] <= NODE_NIL;
                        r_last[hidx]  <= NODE_NIL;
                        r_cur[hidx]   <= NODE_NIL;
                        r_size[hidx]  <= '0;
                        r_pe[hidx]    <= 1'b0;
                        r_res_item    <= '0;
                        r_res_status  <= ST_OK;
                        r_state       <= S_OUT;
                    end
                end
                // join second list onto the target
                S_CAT1: begin
                    if (live2) begin
                        if (nd(hf)) begin
                            if (!nd(r_l1)) begin
                                r_first[hidx] <= hf;
                            end
                            r_last[hidx] <= hl;
                            r_size[hidx] <= r_size1 + hs;
                        end
                        r_state <= S_CAT2;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CAT2: begin
                    r_inuse[hidx2] <= 1'b0;
                    r_nfree[hidx2] <= r_fhi;
                    r_fhi          <= HW'(hidx2);
                    r_first[hidx2] <= NODE_NIL;
                    r_last[hidx2]  <= NODE_NIL;
                    r_cur[hidx2]   <= NODE_NIL;
                    r_size[hidx2]  <= '0;
                    r_pe[hidx2]    <= 1'b0;
                    r_res_status   <= ST_OK;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, r_res_newh, cnt,
                                        (r_res_status == ST_OK) ? 32'(r_res_item) : 32'd0,
                                        r_res_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill counter never passes the pool size
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NUM_N)
        else $error("node fill count beyond pool");

    // returned nodes always come from the part of the pool already handed out
    a_free_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fhead == NODE_NIL) || (r_fhead < NW'(r_fill)))
        else $error("free list head outside handed out nodes");

    // an accepted command goes straight to decode
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted command not decoded");

    // a loaded response never carries an undefined status
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ((r_res_status == ST_OK) || (r_res_status == ST_NOFREE)
                                || (r_res_status == ST_NONE)))
        else $error("bad status code");

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
    import mlcm_pkg::*;

    localparam int NLISTS = 16;
    localparam int NNODES = 128;
    localparam int NODE_NULL = NNODES;
    localparam int HEAD_NULL = NLISTS;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] item_value;
        logic [3:0]  second_handle;
        logic [3:0]  list_handle;
        logic [3:0]  operation;
    } command_t;

    typedef struct packed {
        logic [3:0]  new_handle;
        logic [7:0]  node_count;
        logic [31:0] item_out;
        logic [1:0]  status;
    } response_t;

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata;
    logic o_m_tvalid;
    logic i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    multi_list_cursor_manager dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    // shadow of the list manager state
    logic [31:0] sh_item [NNODES];
    int sh_next [NNODES];
    int sh_prev [NNODES];
    int sh_free_node;
    int sh_first [NLISTS];
    int sh_last [NLISTS];
    int sh_cursor [NLISTS];
    int sh_size [NLISTS];
    bit sh_past_end [NLISTS];
    int sh_head_next [NLISTS];
    int sh_free_head;
    bit sh_in_use [NLISTS];

    command_t  pending_cmds[$];
    response_t expected_resps[$];
    int  sent_count;
    bit  stim_done;
    bit  failed;
    bit  quiet_phase;
    bit  hold_off_req;
    int  cycle_count;
    int  src_gap;
    int  sink_gap;
    int  hold_off;

    function automatic bit is_node(int n);
        return n >= 0 && n < NNODES;
    endfunction

    // link node n after node at (null: front); n becomes the cursor
    function automatic void link_after(int h, int at, int n);
        int nx;
        nx = is_node(at) ? sh_next[at] : sh_first[h];
        sh_prev[n] = is_node(at) ? at : NODE_NULL;
        sh_next[n] = is_node(nx) ? nx : NODE_NULL;
        if (is_node(at)) sh_next[at] = n; else sh_first[h] = n;
        if (is_node(nx)) sh_prev[nx] = n; else sh_last[h] = n;
        sh_size[h]++;
        sh_cursor[h] = n;
        sh_past_end[h] = 1'b0;
    endfunction

    // unlink node n and return it to the pool; cursor moves to its successor
    function automatic logic [31:0] unlink_node(int h, int n);
        int p;
        int x;
        p = sh_prev[n];
        x = sh_next[n];
        if (is_node(p)) sh_next[p] = x; else sh_first[h] = is_node(x) ? x : NODE_NULL;
        if (is_node(x)) sh_prev[x] = p; else sh_last[h] = is_node(p) ? p : NODE_NULL;
        if (sh_size[h] > 0) sh_size[h]--;
        sh_next[n] = sh_free_node;
        sh_prev[n] = NODE_NULL;
        sh_free_node = n;
        sh_cursor[h] = is_node(x) ? x : NODE_NULL;
        sh_past_end[h] = !is_node(x);
        return sh_item[n];
    endfunction

    function automatic void release_head(int h);
        sh_first[h] = NODE_NULL;
        sh_last[h] = NODE_NULL;
        sh_cursor[h] = NODE_NULL;
        sh_size[h] = 0;
        sh_past_end[h] = 1'b0;
        sh_in_use[h] = 1'b0;
        sh_head_next[h] = sh_free_head;
        sh_free_head = h;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < NNODES; i++) begin
            sh_item[i] = '0;
            sh_next[i] = i + 1;
            sh_prev[i] = NODE_NULL;
        end
        sh_free_node = 0;
        for (int i = 0; i < NLISTS; i++) begin
            sh_first[i] = NODE_NULL;
            sh_last[i] = NODE_NULL;
            sh_cursor[i] = NODE_NULL;
            sh_size[i] = 0;
            sh_past_end[i] = 1'b0;
            sh_in_use[i] = 1'b0;
            sh_head_next[i] = i + 1;
        end
        sh_free_head = 0;
    endfunction

    // apply one command to the shadow state and give the expected response
    function automatic response_t apply_command(command_t cmd);
        response_t r;
        int h;
        int h2;
        int counted;
        int c;
        int n;
        int at;
        int nh;
        int f2;
        int l1;
        bit live;
        bit show;
        bit fwd;
        logic [1:0] st;
        logic [31:0] item;
        logic [3:0] newh;
        h = int'(cmd.list_handle);
        h2 = int'(cmd.second_handle);
        counted = h;
        live = sh_in_use[h];
        show = 1'b0;
        st = ST_NONE;
        item = '0;
        newh = '0;
        if (cmd.operation == OP_CREATE) begin
            if (sh_free_head < NLISTS) begin
                nh = sh_free_head;
                sh_free_head = sh_head_next[nh];
                sh_head_next[nh] = HEAD_NULL;
                sh_in_use[nh] = 1'b1;
                sh_first[nh] = NODE_NULL;
                sh_last[nh] = NODE_NULL;
                sh_cursor[nh] = NODE_NULL;
                sh_size[nh] = 0;
                sh_past_end[nh] = 1'b0;
                newh = nh[3:0];
                counted = nh;
                st = ST_OK;
            end else begin
                st = ST_NOFREE;
                counted = NLISTS;
            end
        end else if (live) begin
            c = sh_cursor[h];
            case (cmd.operation)
                OP_FREE: begin
                    while (is_node(sh_last[h])) void'(unlink_node(h, sh_last[h]));
                    release_head(h);
                    st = ST_OK;
                end
                OP_COUNT: st = ST_OK;
                OP_FIRST, OP_LAST: begin
                    c = (cmd.operation == OP_FIRST) ? sh_first[h] : sh_last[h];
                    sh_cursor[h] = is_node(c) ? c : NODE_NULL;
                    sh_past_end[h] = 1'b0;
                    show = 1'b1;
                end
                OP_NEXT, OP_PREV: begin
                    fwd = (cmd.operation == OP_NEXT);
                    if (!is_node(c)) begin
                        if (sh_past_end[h] != fwd) c = fwd ? sh_first[h] : sh_last[h];
                    end else begin
                        c = fwd ? sh_next[c] : sh_prev[c];
                    end
                    if (is_node(c)) begin
                        sh_cursor[h] = c;
                        sh_past_end[h] = 1'b0;
                    end else begin
                        sh_cursor[h] = NODE_NULL;
                        sh_past_end[h] = fwd;
                    end
                    show = 1'b1;
                end
                OP_CURR: show = 1'b1;
                OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
                    n = sh_free_node;
                    if (!is_node(n)) begin
                        st = ST_NOFREE;
                    end else begin
                        sh_free_node = sh_next[n];
                        sh_item[n] = cmd.item_value;
                        if (cmd.operation == OP_APPEND) at = sh_last[h];
                        else if (cmd.operation == OP_PREPEND) at = NODE_NULL;
                        else if (!is_node(c)) at = sh_past_end[h] ? sh_last[h] : NODE_NULL;
                        else at = (cmd.operation == OP_INS_AFTER) ? c : sh_prev[c];
                        link_after(h, at, n);
                        st = ST_OK;
                    end
                end
                OP_REMOVE: begin
                    if (is_node(c)) begin
                        item = unlink_node(h, c);
                        st = ST_OK;
                    end
                end
                OP_TRIM: begin
                    if (is_node(sh_last[h])) begin
                        item = unlink_node(h, sh_last[h]);
                        sh_cursor[h] = is_node(sh_last[h]) ? sh_last[h] : NODE_NULL;
                        sh_past_end[h] = 1'b0;
                        st = ST_OK;
                    end
                end
                OP_CONCAT: begin
                    if (sh_in_use[h2] && h2 != h) begin
                        f2 = sh_first[h2];
                        if (is_node(f2)) begin
                            l1 = sh_last[h];
                            if (is_node(l1)) begin
                                sh_next[l1] = f2;
                                sh_prev[f2] = l1;
                            end else begin
                                sh_first[h] = f2;
                            end
                            sh_last[h] = sh_last[h2];
                            sh_size[h] = sh_size[h] + sh_size[h2];
                        end
                        release_head(h2);
                        st = ST_OK;
                    end
                end
                default: ;
            endcase
            if (show) begin
                c = sh_cursor[h];
                if (is_node(c)) begin
                    item = sh_item[c];
                    st = ST_OK;
                end
            end
        end
        r.status = st;
        r.item_out = (st == ST_OK) ? item : '0;
        r.node_count = (counted < NLISTS && sh_in_use[counted]) ? sh_size[counted][7:0] : '0;
        r.new_handle = newh;
        return r;
    endfunction

    function automatic command_t make_cmd(logic [3:0] op, logic [3:0] h, logic [3:0] h2,
                                          logic [31:0] v);
        command_t c;
        c.operation = op;
        c.list_handle = h;
        c.second_handle = h2;
        c.item_value = v;
        return c;
    endfunction

    // random command, biased towards live handles and sensible operations
    function automatic command_t random_cmd(int live_bias);
        logic [3:0] h;
        logic [3:0] h2;
        logic [3:0] op;
        logic [31:0] v;
        int pick;
        h = 4'($urandom_range(0, 15));
        h2 = 4'($urandom_range(0, 15));
        v = $urandom();
        if ($urandom_range(0, 99) < live_bias) begin
            for (int i = 0; i < 8; i++) begin
                if (!sh_in_use[h]) h = 4'($urandom_range(0, 15));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) op = OP_CREATE;
        else if (pick < 11) op = OP_FREE;
        else if (pick < 40) op = 4'($urandom_range(OP_INS_AFTER, OP_PREPEND));
        else if (pick < 75) op = 4'($urandom_range(OP_COUNT, OP_CURR));
        else if (pick < 92) op = 4'($urandom_range(OP_REMOVE, OP_TRIM));
        else if (pick < 97) op = OP_CONCAT;
        else op = 4'd15;
        return make_cmd(op, h, h2, v);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus: the queue is filled here, the predictor runs as the driver accepts
    initial begin
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        quiet_phase = 1'b0;
        hold_off_req = 1'b0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: bad handle, extremes, every operation and cursor corner
        pending_cmds.push_back(make_cmd(OP_COUNT, 4'd15, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_FIRST, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_TRIM, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_PREV, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_INS_AFTER, 4'd0, 4'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(OP_INS_BEFORE, 4'd0, 4'd0, 32'h0000_0000));
        pending_cmds.push_back(make_cmd(OP_APPEND, 4'd0, 4'd0, 32'hA5A5_5A5A));
        pending_cmds.push_back(make_cmd(OP_PREPEND, 4'd0, 4'd0, 32'h5A5A_A5A5));
        pending_cmds.push_back(make_cmd(OP_LAST, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_NEXT, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_NEXT, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CURR, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_INS_BEFORE, 4'd0, 4'd0, 32'h1234_5678));
        pending_cmds.push_back(make_cmd(OP_PREV, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_APPEND, 4'd1, 4'd0, 32'h8000_0001));
        pending_cmds.push_back(make_cmd(OP_CONCAT, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(OP_CONCAT, 4'd0, 4'd1, 32'h0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 4'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(4'd15, 4'd0, 4'd15, 32'h0));
        pending_cmds.push_back(make_cmd(OP_FREE, 4'd0, 4'd0, 32'h0));
        wait (pending_cmds.size() == 0);

        // exhaust head pool and node pool
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(make_cmd(OP_CREATE, 4'd0, 4'd0, 32'd0));
        for (int i = 0; i < 130; i++)
            pending_cmds.push_back(make_cmd(OP_APPEND, 4'd15 - 4'(i % 2), 4'd0, $urandom()));
        // long receiver hold-off while the sender keeps offering
        hold_off_req = 1'b1;
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(make_cmd(OP_FREE, 4'(i), 4'd0, 32'd0));
        wait (pending_cmds.size() == 0);

        // random part: content chosen when the queue runs low so the bias tracks state
        for (int i = 0; i < 700; i++) begin
            wait (pending_cmds.size() < 2);
            if (i == 600) quiet_phase = 1'b1;
            pending_cmds.push_back(random_cmd(90));
        end
        wait (pending_cmds.size() == 0 && !i_s_tvalid);
        stim_done = 1'b1;
    end

    // driver: drive at the falling edge, predict at the accepting rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_resps.push_back(apply_command(command_t'(i_s_tdata[43:0])));
            void'(pending_cmds.pop_front());
            sent_count++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            src_gap <= 0;
        end else if (src_gap > 0) begin
            i_s_tvalid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (pending_cmds.size() > 0) begin
            if (!quiet_phase && !i_s_tvalid && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(1, 10);
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {4'b0000, pending_cmds[0]};
            end
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure, with one long hold-off counted here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_gap <= 0;
            hold_off <= 0;
        end else if (hold_off_req && hold_off == 0) begin
            i_m_tready <= 1'b0;
            hold_off <= 1;
        end else if (hold_off > 0 && hold_off < 200) begin
            i_m_tready <= 1'b0;
            hold_off <= hold_off + 1;
        end else if (sink_gap > 0) begin
            i_m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            sink_gap <= $urandom_range(1, 10);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: compare each response transaction with the oldest expectation
    always @(posedge i_clk) begin
        response_t got;
        response_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = response_t'(o_m_tdata[45:0]);
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_resps.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    failed = 1'b1;
                end
                if (got.item_out !== want.item_out) begin
                    $display("%0t: item expected %h actual %h", $time, want.item_out,
                             got.item_out);
                    failed = 1'b1;
                end
                if (got.node_count !== want.node_count) begin
                    $display("%0t: count expected %0d actual %0d", $time, want.node_count,
                             got.node_count);
                    failed = 1'b1;
                end
                if (got.new_handle !== want.new_handle) begin
                    $display("%0t: handle expected %0d actual %0d", $time, want.new_handle,
                             got.new_handle);
                    failed = 1'b1;
                end
            end
        end
    end

    // end of run and watchdog
    initial begin
        failed = 1'b0;
        sent_count = 0;
        cycle_count = 0;
        fork
            begin
                wait (stim_done && expected_resps.size() == 0);
                repeat (400) @(posedge i_clk);
                if (!failed && expected_resps.size() == 0) begin
                    $display("Test completed successfully");
                end else begin
                    if (expected_resps.size() != 0)
                        $display("%0t: %0d responses missing", $time, expected_resps.size());
                    $display("Test completed with failures");
                end
                $finish;
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                $display("%0t: timeout", $time);
                $display("Test completed with failures");
                $finish;
            end
        join
    end

endmodule

`default_nettype wire
